// File: rtl/att_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_pkg
// Shared constants, codes and handshake structs of the tempo tracker.
// ----------------------------------------------------------------------------
package att_pkg;

  localparam int MAX_HISTORY = 16;
  localparam int HIST_AW     = $clog2(MAX_HISTORY);
  localparam int TIMER_BITS  = 32;
  localparam int MS_BITS     = 16;
  localparam int SUM_BITS    = MS_BITS + HIST_AW + 1;
  localparam int MULT_BITS   = 24;
  localparam int DIVD_BITS   = 32;
  localparam int DIVR_BITS   = 24;
  localparam int CNT_BITS    = $clog2(DIVD_BITS);
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 16;

  localparam logic [MULT_BITS-1:0] MULT_ONE = MULT_BITS'(65536);
  localparam logic [MULT_BITS-1:0] MULT_MAX = {MULT_BITS{1'b1}};
  localparam logic [MS_BITS-1:0]   MS_MAX   = {MS_BITS{1'b1}};

  // commands
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;
  localparam logic [1:0] CMD_RESTART  = 2'd3;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_INTERVAL_MODE  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HISTORY_LENGTH = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_INTERVAL   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_INTERVAL   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BEAT_THRESH    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SUBDIVISIONS   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SAMPLES_PER_MS = 3'd6;
  localparam logic [CFG_AW-1:0] REG_INITIAL_PERIOD = 3'd7;

  // register reset values
  localparam logic [4:0]  RST_HISTORY_LENGTH = 5'd4;
  localparam logic [15:0] RST_MIN_INTERVAL   = 16'd100;
  localparam logic [15:0] RST_MAX_INTERVAL   = 16'd2000;
  localparam logic [15:0] RST_BEAT_THRESH    = 16'd500;
  localparam logic [7:0]  RST_SUBDIVISIONS   = 8'd1;
  localparam logic [9:0]  RST_SAMPLES_PER_MS = 10'd48;
  localparam logic [15:0] RST_INITIAL_PERIOD = 16'd500;

  typedef struct packed {
    logic                 start;
    logic [DIVD_BITS-1:0] dividend;
    logic [DIVR_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIVD_BITS-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/adaptive_tempo_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_tempo_tracker
// Follows playing tempo from tick, note-on, note-off and restart requests and
// returns the period multiplier (Q8.16) with every request.
// ----------------------------------------------------------------------------
// One request is handled at a time; each gives exactly one result. Tick,
// restart and a note that measures nothing go from EXEC straight to EMIT; a
// note whose interval falls outside the window runs the millisecond divide
// first, and an accepted interval then sums min(history_length, 16) history
// entries and runs the mean divide and, unless beat_thresh_ms or subdivisions
// is zero, the multiplier divide. EMIT waits while a result is still held in
// the output register. The divides use the shared bit-serial divider, which
// runs 32 steps each, and the sum reads the history RAM one entry per cycle.
// History entries not written since reset or restart read as the fill value
// held at that time.
module adaptive_tempo_tracker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output      logic                       s_tready,
  input  wire logic [15:0]                s_tdata,   // sample_count
  input  wire logic [1:0]                 s_tuser,   // cmd
  output      logic                       m_tvalid,
  input  wire logic                       m_tready,
  output      logic [39:0]                m_tdata,   // period_multiplier, interval_ms
  output      logic                       m_tuser,   // updated
  input  wire logic                       cfg_we,
  input  wire logic [att_pkg::CFG_AW-1:0] cfg_index,
  input  wire logic [att_pkg::CFG_DW-1:0] cfg_data
);
  import att_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_DIV_MS   = 3'd2;
  localparam logic [2:0] ST_SUM      = 3'd3;
  localparam logic [2:0] ST_DIV_MEAN = 3'd4;
  localparam logic [2:0] ST_DIV_MULT = 3'd5;
  localparam logic [2:0] ST_EMIT     = 3'd6;

  // configuration
  logic        interval_mode;
  logic [4:0]  history_length;
  logic [15:0] min_interval_ms;
  logic [15:0] max_interval_ms;
  logic [15:0] beat_thresh_ms;
  logic [7:0]  subdivisions;
  logic [9:0]  samples_per_ms;
  logic [15:0] initial_period_ms;

  // state
  logic [2:0]            state;
  logic [1:0]            cmd;
  logic [15:0]           count;
  logic [TIMER_BITS-1:0] sample_timer;
  logic [TIMER_BITS-1:0] last_note_time;
  logic [HIST_AW-1:0]    ptr;
  logic [MAX_HISTORY-1:0] hist_valid;
  logic [MS_BITS-1:0]    fill_value;
  logic [MULT_BITS-1:0]  multiplier;
  logic [HIST_AW:0]      n_len;
  logic [HIST_AW:0]      rd_cnt;
  logic                  rd_pend;
  logic                  rd_valid;
  logic [SUM_BITS-1:0]   sum;
  logic [MULT_BITS-1:0]  prod;
  logic [MS_BITS-1:0]    ms;
  logic                  upd;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  // output register
  logic [MULT_BITS-1:0]  out_mult;
  logic [MS_BITS-1:0]    out_ms;
  logic                  out_upd;

  // history RAM
  logic                  ram_we;
  logic [HIST_AW-1:0]    ram_raddr;
  logic [MS_BITS-1:0]    ram_rdata;

  logic                  in_window;
  logic                  rd_issue;
  logic                  out_free;
  logic                  measure_on;
  logic                  div_go;
  logic [TIMER_BITS-1:0] elapsed;
  logic [DIVR_BITS-1:0]  spm_div;

  assign s_tready   = state == ST_IDLE;
  assign out_free   = !m_tvalid || m_tready;
  assign in_window  = (div_rsp.quotient > DIVD_BITS'(min_interval_ms)) &&
                      (div_rsp.quotient < DIVD_BITS'(max_interval_ms));
  assign ram_we     = (state == ST_DIV_MS) && div_rsp.done && in_window;
  assign rd_issue   = (state == ST_SUM) && (rd_cnt < n_len);
  assign ram_raddr  = HIST_AW'(ptr - HIST_AW'(1) - rd_cnt[HIST_AW-1:0]);
  assign elapsed    = sample_timer - last_note_time;
  assign spm_div    = (samples_per_ms == '0) ? DIVR_BITS'(1) : DIVR_BITS'(samples_per_ms);
  assign measure_on = (history_length != '0) &&
                      (((cmd == CMD_NOTE_ON) && !interval_mode) ||
                       ((cmd == CMD_NOTE_OFF) && interval_mode));
  assign div_go     = ((state == ST_EXEC) && measure_on) ||
                      ((state == ST_SUM) && !rd_issue && !rd_pend) ||
                      ((state == ST_DIV_MEAN) && div_rsp.done && (prod != '0));

  att_ram #(
    .WIDTH (MS_BITS),
    .DEPTH (MAX_HISTORY)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (div_rsp.quotient[MS_BITS-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  att_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_mode     <= 1'b0;
      history_length    <= RST_HISTORY_LENGTH;
      min_interval_ms   <= RST_MIN_INTERVAL;
      max_interval_ms   <= RST_MAX_INTERVAL;
      beat_thresh_ms    <= RST_BEAT_THRESH;
      subdivisions      <= RST_SUBDIVISIONS;
      samples_per_ms    <= RST_SAMPLES_PER_MS;
      initial_period_ms <= RST_INITIAL_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERVAL_MODE:  interval_mode     <= cfg_data[0];
        REG_HISTORY_LENGTH: history_length    <= cfg_data[4:0];
        REG_MIN_INTERVAL:   min_interval_ms   <= cfg_data;
        REG_MAX_INTERVAL:   max_interval_ms   <= cfg_data;
        REG_BEAT_THRESH:    beat_thresh_ms    <= cfg_data;
        REG_SUBDIVISIONS:   subdivisions      <= cfg_data[7:0];
        REG_SAMPLES_PER_MS: samples_per_ms    <= cfg_data[9:0];
        REG_INITIAL_PERIOD: initial_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sample_timer   <= '0;
      last_note_time <= '0;
      ptr            <= '0;
      hist_valid     <= '0;
      fill_value     <= RST_INITIAL_PERIOD;
      multiplier     <= MULT_ONE;
      rd_pend        <= 1'b0;
      div_req.start  <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      div_req.start <= div_go;
      if ((state == ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tuser;
            count <= s_tdata;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          upd   <= 1'b0;
          ms    <= '0;
          n_len <= (history_length > 5'(MAX_HISTORY)) ? (HIST_AW+1)'(MAX_HISTORY)
                                                     : (HIST_AW+1)'(history_length);
          state <= measure_on ? ST_DIV_MS : ST_EMIT;
          case (cmd)
            CMD_TICK: sample_timer <= sample_timer + TIMER_BITS'(count);
            CMD_NOTE_ON: last_note_time <= sample_timer;
            CMD_RESTART: begin
              hist_valid <= '0;
              ptr        <= '0;
              fill_value <= initial_period_ms;
              multiplier <= MULT_ONE;
            end
            default: ;
          endcase
          if (measure_on) begin
            div_req.dividend <= DIVD_BITS'(elapsed);
            div_req.divisor  <= spm_div;
          end
        end
        ST_DIV_MS: begin
          if (div_rsp.done) begin
            ms <= (div_rsp.quotient > DIVD_BITS'(MS_MAX)) ? MS_MAX
                                                         : div_rsp.quotient[MS_BITS-1:0];
            if (in_window) begin
              upd             <= 1'b1;
              hist_valid[ptr] <= 1'b1;
              ptr             <= ptr + HIST_AW'(1);
              sum             <= '0;
              rd_cnt          <= '0;
              state           <= ST_SUM;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SUM: begin
          prod    <= MULT_BITS'(beat_thresh_ms) * MULT_BITS'(subdivisions);
          rd_pend <= rd_issue;
          if (rd_issue) begin
            rd_valid <= hist_valid[ram_raddr];
            rd_cnt   <= rd_cnt + (HIST_AW+1)'(1);
          end
          if (rd_pend) begin
            sum <= sum + SUM_BITS'(rd_valid ? ram_rdata : fill_value);
          end
          if (!rd_issue && !rd_pend) begin
            div_req.dividend <= DIVD_BITS'(sum);
            div_req.divisor  <= DIVR_BITS'(n_len);
            state            <= ST_DIV_MEAN;
          end
        end
        ST_DIV_MEAN: begin
          if (div_rsp.done) begin
            if (prod == '0) begin
              multiplier <= MULT_MAX;
              state      <= ST_EMIT;
            end else begin
              div_req.dividend <= {div_rsp.quotient[MS_BITS-1:0], {MS_BITS{1'b0}}};
              div_req.divisor  <= prod;
              state            <= ST_DIV_MULT;
            end
          end
        end
        ST_DIV_MULT: begin
          if (div_rsp.done) begin
            multiplier <= (div_rsp.quotient[DIVD_BITS-1:MULT_BITS] != '0) ? MULT_MAX
                          : div_rsp.quotient[MULT_BITS-1:0];
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_mult <= multiplier;
            out_ms   <= ms;
            out_upd  <= upd;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {out_ms, out_mult};
  assign m_tuser = out_upd;

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_EXEC)
    else $error("accepted request did not start execution");
  a_upd_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[39:24] != '0)
    else $error("accepted interval reported as zero");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_MS || state == ST_DIV_MEAN || state == ST_DIV_MULT))
    else $error("divider result outside a divide state");
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> rd_cnt <= n_len)
    else $error("history read count beyond history length");
`endif

endmodule
`default_nettype wire

// File: rtl/att_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module att_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/att_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_div
// Bit-serial restoring divider, one quotient bit per cycle. Divisor must be
// nonzero.
// ----------------------------------------------------------------------------
module att_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire att_pkg::div_req_t req,
  output      att_pkg::div_rsp_t rsp
);
  import att_pkg::*;

  logic                 busy;
  logic                 done;
  logic [CNT_BITS-1:0]  cnt;
  logic [DIVD_BITS-1:0] quo;
  logic [DIVR_BITS-1:0] rem;
  logic [DIVR_BITS-1:0] dvs;
  logic [DIVR_BITS:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[DIVD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(DIVD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIVD_BITS-2:0], fits};
      rem <= fits ? DIVR_BITS'(trial - {1'b0, dvs}) : trial[DIVR_BITS-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held longer than one cycle");
`endif

endmodule
`default_nettype wire

// File: dv/tempo_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempo_check
// Watches the request, result and register ports of the tempo tracker, keeps
// its own copy of the tracker state, predicts one result per accepted request
// and compares every returned result field by field, in order.
// ----------------------------------------------------------------------------
module tempo_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [15:0]                s_tdata,   // sample_count
  input  logic [1:0]                 s_tuser,   // cmd
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [39:0]                m_tdata,   // period_multiplier, interval_ms
  input  logic                       m_tuser,   // updated
  input  logic                       cfg_we,
  input  logic [att_pkg::CFG_AW-1:0] cfg_index,
  input  logic [att_pkg::CFG_DW-1:0] cfg_data,
  output int                         errors,
  output int                         outstanding
);
  import att_pkg::*;

  typedef struct packed {
    logic [MULT_BITS-1:0] mult;
    logic                 updated;
    logic [MS_BITS-1:0]   ms;
  } tempo_result_t;

  // register copy
  logic        mode;
  logic [4:0]  hist_len;
  logic [15:0] min_ms;
  logic [15:0] max_ms;
  logic [15:0] beat_ms;
  logic [7:0]  subdiv;
  logic [9:0]  spm;
  logic [15:0] init_period;

  // tracker state
  logic [TIMER_BITS-1:0] timer;
  logic [TIMER_BITS-1:0] note_time;
  logic [MS_BITS-1:0]    hist [MAX_HISTORY];
  logic [HIST_AW-1:0]    wr_ptr;
  logic [MULT_BITS-1:0]  mult;

  tempo_result_t tempo_q [$];
  int            fail_cnt = 0;
  int            open_cnt = 0;

  assign errors      = fail_cnt;
  assign outstanding = open_cnt;

  function automatic void refill_hist();
    for (int i = 0; i < MAX_HISTORY; i++) hist[i] = init_period;
    wr_ptr = '0;
  endfunction

  function automatic void reset_tracker();
    mode        = 1'b0;
    hist_len    = RST_HISTORY_LENGTH;
    min_ms      = RST_MIN_INTERVAL;
    max_ms      = RST_MAX_INTERVAL;
    beat_ms     = RST_BEAT_THRESH;
    subdiv      = RST_SUBDIVISIONS;
    spm         = RST_SAMPLES_PER_MS;
    init_period = RST_INITIAL_PERIOD;
    timer       = '0;
    note_time   = '0;
    refill_hist();
    mult        = MULT_ONE;
  endfunction

  function automatic void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_INTERVAL_MODE:  mode        = val[0];
      REG_HISTORY_LENGTH: hist_len    = val[4:0];
      REG_MIN_INTERVAL:   min_ms      = val;
      REG_MAX_INTERVAL:   max_ms      = val;
      REG_BEAT_THRESH:    beat_ms     = val;
      REG_SUBDIVISIONS:   subdiv      = val[7:0];
      REG_SAMPLES_PER_MS: spm         = val[9:0];
      REG_INITIAL_PERIOD: init_period = val;
      default: ;
    endcase
  endfunction

  // Measures the interval since the last note-on; returns 1 when it enters
  // the history and moves the multiplier.
  function automatic logic take_interval(output logic [MS_BITS-1:0] ms_out);
    logic [TIMER_BITS-1:0] elapsed;
    logic [31:0]           ms;
    logic [9:0]            spm_eff;
    logic [4:0]            n;
    logic [HIST_AW-1:0]    idx;
    logic [63:0]           sum;
    logic [63:0]           mean;
    logic [63:0]           divr;
    logic [63:0]           q;
    ms_out = '0;
    if (hist_len == 0) return 1'b0;
    elapsed = timer - note_time;
    spm_eff = (spm == 0) ? 10'd1 : spm;
    ms      = elapsed / spm_eff;
    ms_out  = (ms > 32'(MS_MAX)) ? MS_MAX : ms[MS_BITS-1:0];
    if (!(ms > min_ms && ms < max_ms)) return 1'b0;
    hist[wr_ptr] = ms[MS_BITS-1:0];
    wr_ptr       = wr_ptr + 1'b1;
    n   = (hist_len > MAX_HISTORY) ? 5'(MAX_HISTORY) : hist_len;
    sum = '0;
    idx = wr_ptr;
    for (int i = 0; i < n; i++) begin
      idx = idx - 1'b1;
      sum = sum + hist[idx];
    end
    mean = sum / n;
    divr = 64'(beat_ms) * 64'(subdiv);
    if (divr == 0) begin
      mult = MULT_MAX;
    end else begin
      q    = (mean << 16) / divr;
      mult = (q > 64'(MULT_MAX)) ? MULT_MAX : q[MULT_BITS-1:0];
    end
    return 1'b1;
  endfunction

  function automatic tempo_result_t track_request(logic [1:0] cmd, logic [15:0] count);
    tempo_result_t      r;
    logic [MS_BITS-1:0] ms;
    logic               hit;
    ms  = '0;
    hit = 1'b0;
    case (cmd)
      CMD_TICK:    timer = timer + count;
      CMD_NOTE_ON: begin
        if (!mode) hit = take_interval(ms);
        note_time = timer;
      end
      CMD_NOTE_OFF: begin
        if (mode) hit = take_interval(ms);
      end
      default: begin
        refill_hist();
        mult = MULT_ONE;
      end
    endcase
    r.mult    = mult;
    r.updated = hit;
    r.ms      = ms;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tempo_result_t want;
    tempo_result_t got;
    if (rst) begin
      reset_tracker();
      tempo_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.mult    = m_tdata[23:0];
        got.ms      = m_tdata[39:24];
        got.updated = m_tuser;
        if (tempo_q.size() == 0) begin
          fail_cnt++;
          $error("result with no request outstanding: period_multiplier %0d", got.mult);
        end else begin
          want = tempo_q.pop_front();
          if (got.mult !== want.mult) begin
            fail_cnt++;
            $error("period_multiplier: expected %0d, got %0d", want.mult, got.mult);
          end
          if (got.updated !== want.updated) begin
            fail_cnt++;
            $error("updated: expected %0d, got %0d", want.updated, got.updated);
          end
          if (got.ms !== want.ms) begin
            fail_cnt++;
            $error("interval_ms: expected %0d, got %0d", want.ms, got.ms);
          end
        end
      end
      if (cfg_we) write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) tempo_q.push_back(track_request(s_tuser, s_tdata));
    end
    open_cnt <= tempo_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick, note and restart requests into the tempo tracker under a
// series of register settings, with random gaps on both sides and a closing
// stretch without gaps. Results are checked by tempo_check.
// ----------------------------------------------------------------------------
module tb_top;
  import att_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int ITEM_GOAL      = 1400;
  localparam int TAIL_ITEMS     = 100;
  localparam int PHASE_ITEMS    = 110;
  localparam int STALL_PCT      = 23;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_SPAN       = 400000;  // samples per measured interval

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [15:0]       s_tdata;   // sample_count
  logic [1:0]        s_tuser;   // cmd
  logic              m_tvalid;
  logic              m_tready;
  logic [39:0]       m_tdata;   // period_multiplier, interval_ms
  logic              m_tuser;   // updated
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  int                errors;
  int                outstanding;
  logic              stall_en;
  int                sent;
  logic [CFG_DW-1:0] regs [8];
  int                quiet;
  int                ph;

  always #(CLK_HALF) clk = ~clk;

  adaptive_tempo_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tempo_check tempo_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) m_tready <= !(stall_en && $urandom_range(99) < STALL_PCT);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [15:0] count);
    if (stall_en && $urandom_range(99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < STALL_PCT);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= count;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_ticks(input int unsigned samples);
    int unsigned chunk;
    while (samples > 0) begin
      chunk = $urandom_range((samples > 65535) ? 65535 : samples, 1);
      send_req(CMD_TICK, 16'(chunk));
      samples = samples - chunk;
    end
  endtask

  // wait until every request has its result back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_AW'(i);
      cfg_data  <= regs[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // one note interval, mostly aimed inside the acceptance window
  task automatic play_beat();
    int unsigned spm_eff;
    int unsigned cap_ms;
    int unsigned lo;
    int unsigned hi;
    int unsigned target;
    spm_eff = (regs[REG_SAMPLES_PER_MS][9:0] == 0) ? 1 : regs[REG_SAMPLES_PER_MS][9:0];
    cap_ms  = MAX_SPAN / spm_eff;
    lo      = regs[REG_MIN_INTERVAL] + 1;
    hi      = (regs[REG_MAX_INTERVAL] == 0) ? 0 : regs[REG_MAX_INTERVAL] - 1;
    if (hi > cap_ms) hi = cap_ms;
    if (lo <= hi && $urandom_range(9) < 8) target = $urandom_range(hi, lo);
    else target = $urandom_range(cap_ms);
    if (regs[REG_INTERVAL_MODE][0]) begin
      send_req(CMD_NOTE_ON, 16'($urandom));
      send_ticks(target * spm_eff + $urandom_range(spm_eff - 1));
      send_req(CMD_NOTE_OFF, 16'($urandom));
    end else begin
      send_ticks(target * spm_eff + $urandom_range(spm_eff - 1));
      send_req(CMD_NOTE_ON, 16'($urandom));
    end
  endtask

  task automatic play_noise();
    logic [1:0] cmd;
    case ($urandom_range(2))
      0:       cmd = CMD_TICK;
      1:       cmd = CMD_NOTE_ON;
      default: cmd = CMD_NOTE_OFF;
    endcase
    if ($urandom_range(15) == 0) cmd = CMD_RESTART;
    send_req(cmd, 16'($urandom));
  endtask

  task automatic choose_setting(input int n);
    regs[REG_INTERVAL_MODE]  = CFG_DW'($urandom_range(1));
    regs[REG_HISTORY_LENGTH] = CFG_DW'($urandom_range(16, 1));
    regs[REG_MIN_INTERVAL]   = CFG_DW'($urandom_range(300));
    regs[REG_MAX_INTERVAL]   = regs[REG_MIN_INTERVAL] + CFG_DW'($urandom_range(3000, 200));
    regs[REG_BEAT_THRESH]    = CFG_DW'($urandom_range(1000, 1));
    regs[REG_SUBDIVISIONS]   = CFG_DW'($urandom_range(8, 1));
    regs[REG_SAMPLES_PER_MS] = CFG_DW'($urandom_range(96, 1));
    regs[REG_INITIAL_PERIOD] = CFG_DW'($urandom_range(2000, 1));
    case (n)
      1: begin
        regs[REG_HISTORY_LENGTH] = 16'd31;
        regs[REG_SAMPLES_PER_MS] = 16'd0;
        regs[REG_MIN_INTERVAL]   = 16'd0;
        regs[REG_MAX_INTERVAL]   = 16'hFFFF;
      end
      2: begin
        regs[REG_BEAT_THRESH]   = 16'd0;
        regs[REG_INTERVAL_MODE] = 16'd1;
      end
      3: begin
        regs[REG_SUBDIVISIONS]   = 16'd0;
        regs[REG_HISTORY_LENGTH] = 16'd1;
      end
      4: begin
        // multiplier saturates
        regs[REG_BEAT_THRESH]    = 16'd1;
        regs[REG_SUBDIVISIONS]   = 16'd1;
        regs[REG_INITIAL_PERIOD] = 16'hFFFF;
        regs[REG_HISTORY_LENGTH] = 16'd16;
      end
      5: begin
        regs[REG_BEAT_THRESH]    = 16'hFFFF;
        regs[REG_SUBDIVISIONS]   = 16'd255;
        regs[REG_SAMPLES_PER_MS] = 16'd1023;
        regs[REG_HISTORY_LENGTH] = 16'd16;
      end
      6: regs[REG_HISTORY_LENGTH] = 16'd0;
      7: regs[REG_HISTORY_LENGTH] = 16'd2;
      8: regs[REG_HISTORY_LENGTH] = 16'd16;  // grows over older ring entries
      9: begin
        for (int i = 0; i < 8; i++) regs[i] = CFG_DW'($urandom);
      end
      10: begin
        regs[REG_MIN_INTERVAL] = 16'hFFFF;
        regs[REG_MAX_INTERVAL] = 16'd0;
      end
      11: begin
        regs[REG_INTERVAL_MODE]  = 16'd1;
        regs[REG_HISTORY_LENGTH] = 16'd17;
      end
      default: ;
    endcase
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_TICK;
    cfg_we    = 1'b0;
    cfg_index = REG_INTERVAL_MODE;
    cfg_data  = '0;
    stall_en  = 1'b1;
    sent      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 48 samples per ms, window 100..2000 ms
    send_req(CMD_TICK, 16'h0000);
    send_req(CMD_NOTE_OFF, 16'hFFFF);  // wrong event for the mode
    send_req(CMD_NOTE_ON, 16'h0000);   // zero interval
    send_req(CMD_TICK, 16'hFFFF);
    send_req(CMD_NOTE_ON, 16'h5A5A);   // 1365 ms, accepted
    send_req(CMD_TICK, 16'd4800);
    send_req(CMD_NOTE_ON, 16'hA5A5);   // exactly the lower bound
    send_req(CMD_TICK, 16'd4848);
    send_req(CMD_NOTE_ON, 16'h0000);   // just above it
    send_req(CMD_TICK, 16'hFFFF);
    send_req(CMD_TICK, 16'd30417);
    send_req(CMD_NOTE_ON, 16'h0000);   // 1999 ms
    send_req(CMD_TICK, 16'hFFFF);
    send_req(CMD_TICK, 16'd30465);
    send_req(CMD_NOTE_ON, 16'h0000);   // exactly the upper bound
    send_req(CMD_RESTART, 16'hFFFF);
    send_req(CMD_TICK, 16'hFFFF);
    send_req(CMD_NOTE_ON, 16'h0000);
    send_req(CMD_NOTE_OFF, 16'h0000);
    send_req(CMD_RESTART, 16'h0000);

    for (ph = 0; sent < ITEM_GOAL; ph++) begin
      settle();
      choose_setting(ph);
      write_regs();
      while (sent < ITEM_GOAL && sent < (ph + 1) * PHASE_ITEMS + 20) begin
        if ($urandom_range(99) < 80) play_beat();
        else play_noise();
      end
    end

    // closing stretch without gaps on either side
    stall_en <= 1'b0;
    while (sent < ITEM_GOAL + TAIL_ITEMS) begin
      if ($urandom_range(99) < 80) play_beat();
      else play_noise();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
rtl/att_pkg.sv
rtl/att_ram.sv
rtl/att_div.sv
rtl/adaptive_tempo_tracker.sv
dv/tempo_check.sv
dv/tb_top.sv
